/* rtl/skc_pkg.sv */
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types and constants of the sorted key cache table: table depth,
// function and status codes, cell commands and the entry layout.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int TableDepth = 256;
  localparam int PosW       = $clog2(TableDepth + 1);
  localparam int IdxW       = $clog2(TableDepth);
  localparam int OutPosW    = 9;
  localparam int KeyW       = 32;
  localparam int StampW     = 32;

  localparam logic [31:0] IdleThresholdReset = 32'd1000;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2,
    FN_VICTIM = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_ABSENT  = 2'd1,
    STS_PRESENT = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_REFRESH,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [StampW-1:0] stamp;
    logic              vld;
  } entry_t;

  typedef struct packed {
    cell_op_e          op;
    logic [KeyW-1:0]   key;
    logic [StampW-1:0] stamp;
  } cell_cmd_t;

endpackage

/* rtl/skc_if.sv */
// ----------------------------------------------------------------------------
// skc_if
// Valid/ready channels of the sorted key cache table: request, response
// and threshold write.
// ----------------------------------------------------------------------------
interface skc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] key;
  logic [31:0] now;

  modport source (output valid, func, key, now, input ready);
  modport sink   (input valid, func, key, now, output ready);
endinterface

interface skc_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [8:0] position;
  logic [1:0] status;
  logic [8:0] entry_count;

  modport source (output valid, hit, position, status, entry_count, input ready);
  modport sink   (input valid, hit, position, status, entry_count, output ready);
endinterface

interface skc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/skc_cell.sv */
// ----------------------------------------------------------------------------
// skc_cell
// One table slot: key, last-used stamp and valid bit, with its own probe
// compare and shift from either neighbor.
// ----------------------------------------------------------------------------
module skc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       probe_i,
  input  skc_pkg::cell_cmd_t cmd_i,
  input  skc_pkg::entry_t   left_i,
  input  skc_pkg::entry_t   right_i,
  input  logic              bound_i,
  output skc_pkg::entry_t   entry_o,
  output logic              lt_o,
  output logic              eq_o
);
  import skc_pkg::*;

  logic [KeyW-1:0]   key_q, key_d;
  logic [StampW-1:0] stamp_q, stamp_d;
  logic              vld_q, vld_d;
  logic              lt_q, eq_q;

  assign entry_o = '{key: key_q, stamp: stamp_q, vld: vld_q};
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

  always_comb begin
    key_d   = key_q;
    stamp_d = stamp_q;
    vld_d   = vld_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (!lt_q) begin
          if (bound_i) begin
            key_d   = cmd_i.key;
            stamp_d = cmd_i.stamp;
            vld_d   = 1'b1;
          end else begin
            key_d   = left_i.key;
            stamp_d = left_i.stamp;
            vld_d   = left_i.vld;
          end
        end
      end
      CELL_REMOVE: begin
        if (!lt_q) begin
          key_d   = right_i.key;
          stamp_d = right_i.stamp;
          vld_d   = right_i.vld;
        end
      end
      CELL_REFRESH: begin
        if (bound_i && eq_q) begin
          stamp_d = cmd_i.stamp;
        end
      end
      CELL_ROTATE: begin
        key_d   = right_i.key;
        stamp_d = right_i.stamp;
        vld_d   = right_i.vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    stamp_q <= stamp_d;
    lt_q    <= vld_q && (key_q < probe_i);
    eq_q    <= vld_q && (key_q == probe_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

endmodule

/* rtl/skc_chain.sv */
// ----------------------------------------------------------------------------
// skc_chain
// Row of table cells with neighbor links, insertion boundary detect and
// position encoder.
// ----------------------------------------------------------------------------
module skc_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        probe_i,
  input  skc_pkg::cell_cmd_t cmd_i,
  output skc_pkg::entry_t    head_o,
  output logic [8:0]         pos_o,
  output logic               present_o
);
  import skc_pkg::*;

  entry_t                ent   [TableDepth];
  entry_t                left  [TableDepth];
  entry_t                right [TableDepth];
  logic [TableDepth-1:0] lt;
  logic [TableDepth-1:0] eq;
  logic [TableDepth:0]   bnd;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = '0;
      assign bnd[i]  = !lt[i];
    end else begin : g_rest
      assign left[i] = ent[i-1];
      assign bnd[i]  = lt[i-1] && !lt[i];
    end

    if (i == TableDepth - 1) begin : g_last
      assign right[i] = (cmd_i.op == CELL_ROTATE) ? ent[0] : entry_t'('0);
    end else begin : g_inner
      assign right[i] = ent[i+1];
    end

    skc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe_i),
      .cmd_i   (cmd_i),
      .left_i  (left[i]),
      .right_i (right[i]),
      .bound_i (bnd[i]),
      .entry_o (ent[i]),
      .lt_o    (lt[i]),
      .eq_o    (eq[i])
    );
  end

  assign bnd[TableDepth] = lt[TableDepth-1];
  assign head_o          = ent[0];
  assign present_o       = |(bnd[TableDepth-1:0] & eq);

  always_comb begin
    pos_o = '0;
    for (int i = 0; i <= TableDepth; i++) begin
      if (bnd[i]) begin
        pos_o = pos_o | OutPosW'(i);
      end
    end
  end

endmodule

/* rtl/sorted_key_cache_table_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_cache_table_unit
// Sorted key table with last-used stamps and idle-age victim selection.
// Lookup, insert and remove: cell compare, then boundary encode and cell
// update; a new request is taken only after the response is registered.
// Victim select: the row rotates once through cell 0; a new request is
// taken only after the scan ends and its response is registered.
// Reset: table empty (valid bits and count cleared), threshold 1000.
// ----------------------------------------------------------------------------
module sorted_key_cache_table_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  skc_req_if.sink   req_i,
  skc_rsp_if.source rsp_o,
  skc_cfg_if.sink   cfg_i
);
  import skc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_UPD  = 4'b0100,
    S_VICT = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  func_e             func_q;
  logic [KeyW-1:0]   key_q;
  logic [StampW-1:0] now_q;
  logic [31:0]       thr_q;
  logic [PosW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              found_q, found_d;
  logic [31:0]       best_q, best_d;
  logic [IdxW-1:0]   vpos_q, vpos_d;

  logic              rsp_vld_q, rsp_vld_d;
  logic              hit_q, hit_d;
  logic [8:0]        pos_q, pos_d;
  status_e           status_q, status_d;
  logic [8:0]        cnt_q, cnt_d;

  cell_cmd_t         cmd;
  entry_t            head;
  logic [8:0]        chain_pos;
  logic              present;
  logic              accept;
  logic              out_free;
  logic              full;
  logic              last;
  logic [31:0]       idle;
  logic              take;

  skc_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .probe_i   (key_q),
    .cmd_i     (cmd),
    .head_o    (head),
    .pos_o     (chain_pos),
    .present_o (present)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign accept            = req_i.valid && req_i.ready;
  assign cfg_i.ready       = 1'b1;
  assign out_free          = !rsp_vld_q || rsp_o.ready;
  assign full              = (count_q == PosW'(TableDepth));
  assign last              = (idx_q == IdxW'(TableDepth - 1));
  assign idle              = now_q - head.stamp;
  assign take              = head.vld && (found_q ? (idle >= best_q) : (idle > best_q));

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.position    = pos_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_count = cnt_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    found_d   = found_q;
    best_d    = best_q;
    vpos_d    = vpos_q;
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    hit_d     = hit_q;
    pos_d     = pos_q;
    status_d  = status_q;
    cnt_d     = cnt_q;
    cmd       = '{op: CELL_HOLD, key: key_q, stamp: now_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          found_d = 1'b0;
          best_d  = thr_q;
          vpos_d  = '0;
          state_d = (func_e'(req_i.func) == FN_VICTIM) ? S_VICT : S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          hit_d = 1'b0;
          pos_d = chain_pos;
          case (func_q)
            FN_LOOKUP: begin
              hit_d    = present;
              status_d = present ? STS_OK : STS_ABSENT;
              if (present) begin
                cmd.op = CELL_REFRESH;
              end
            end
            FN_INSERT: begin
              if (present) begin
                hit_d    = 1'b1;
                status_d = STS_PRESENT;
              end else if (full) begin
                status_d = STS_FULL;
              end else begin
                cmd.op   = CELL_INSERT;
                count_d  = count_q + 1'b1;
                status_d = STS_OK;
              end
            end
            FN_REMOVE: begin
              if (present) begin
                cmd.op   = CELL_REMOVE;
                count_d  = count_q - 1'b1;
                hit_d    = 1'b1;
                status_d = STS_OK;
              end else begin
                status_d = STS_ABSENT;
              end
            end
            default: begin
              status_d = STS_ABSENT;
            end
          endcase
          cnt_d     = OutPosW'(count_d);
          rsp_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_VICT: begin
        if (!last || out_free) begin
          cmd.op = CELL_ROTATE;
          idx_d  = idx_q + 1'b1;
          if (take) begin
            found_d = 1'b1;
            best_d  = idle;
            vpos_d  = idx_q;
          end
          if (last) begin
            hit_d     = found_d;
            pos_d     = found_d ? OutPosW'(vpos_d) : '0;
            status_d  = found_d ? STS_OK : STS_ABSENT;
            cnt_d     = OutPosW'(count_q);
            rsp_vld_d = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      thr_q     <= IdleThresholdReset;
      rsp_vld_q <= 1'b0;
      idx_q     <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(req_i.func);
      key_q  <= req_i.key;
      now_q  <= req_i.now;
    end
    best_q   <= best_d;
    vpos_q   <= vpos_d;
    hit_q    <= hit_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    cnt_q    <= cnt_d;
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_key_cache_table_unit. A queue-fed driver
// sends lookup, insert, remove and victim-select items. A shadow copy of the
// sorted table predicts every response, and a monitor compares the responses
// field by field. The run steps through several throttle settings and idle
// thresholds, fills the table to capacity and then removes entries from it again.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skc_pkg::*;

  typedef struct {
    func_e       fn;
    logic [31:0] key;
    logic [31:0] now;
  } table_op_t;

  typedef struct {
    logic       hit;
    logic [8:0] position;
    status_e    status;
    logic [8:0] entry_count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  skc_req_if req_bus ();
  skc_rsp_if rsp_bus ();
  skc_cfg_if cfg_bus ();

  sorted_key_cache_table_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  table_op_t     op_q[$];
  table_result_t expected_q[$];

  logic [31:0] shadow_key   [TableDepth];
  logic [31:0] shadow_stamp [TableDepth];
  int          shadow_count;
  logic [31:0] shadow_threshold;

  logic [31:0] key_pool [1024];
  logic [31:0] tick;
  int          send_idle_pct;
  int          rsp_stall_pct;
  int          errors;
  int          op_tally [4];
  int          full_refusals;
  int          victims_found;
  int          peak_count;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic table_result_t predict_table_op(table_op_t op);
    table_result_t r;
    int            p;
    logic [31:0]   best;
    logic [31:0]   idle;
    bit            present;
    r.hit      = 1'b0;
    r.position = '0;
    r.status   = STS_OK;
    if (op.fn == FN_VICTIM) begin
      best     = shadow_threshold;
      r.status = STS_ABSENT;
      // scan downward with strict compare so ties keep the highest index
      for (int i = shadow_count - 1; i >= 0; i--) begin
        idle = op.now - shadow_stamp[i];
        if (idle > best) begin
          best       = idle;
          r.hit      = 1'b1;
          r.position = 9'(i);
          r.status   = STS_OK;
        end
      end
    end else begin
      p = 0;
      while (p < shadow_count && shadow_key[p] < op.key) p++;
      present = 1'b0;
      if (p < shadow_count) present = (shadow_key[p] == op.key);
      r.position = 9'(p);
      case (op.fn)
        FN_LOOKUP: begin
          if (present) begin
            r.hit           = 1'b1;
            shadow_stamp[p] = op.now;
          end else begin
            r.status = STS_ABSENT;
          end
        end
        FN_INSERT: begin
          if (present) begin
            r.hit    = 1'b1;
            r.status = STS_PRESENT;
          end else if (shadow_count >= TableDepth) begin
            r.status = STS_FULL;
          end else begin
            for (int i = shadow_count; i > p; i--) begin
              shadow_key[i]   = shadow_key[i-1];
              shadow_stamp[i] = shadow_stamp[i-1];
            end
            shadow_key[p]   = op.key;
            shadow_stamp[p] = op.now;
            shadow_count++;
          end
        end
        default: begin
          if (present) begin
            for (int i = p; i < shadow_count - 1; i++) begin
              shadow_key[i]   = shadow_key[i+1];
              shadow_stamp[i] = shadow_stamp[i+1];
            end
            shadow_count--;
            r.hit = 1'b1;
          end else begin
            r.status = STS_ABSENT;
          end
        end
      endcase
    end
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  always @(posedge clk_i) begin : drive_requests
    table_op_t     sent;
    table_result_t want;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        sent.fn  = func_e'(req_bus.func);
        sent.key = req_bus.key;
        sent.now = req_bus.now;
        want     = predict_table_op(sent);
        expected_q.push_back(want);
        op_tally[sent.fn]++;
        if (want.status == STS_FULL) full_refusals++;
        if (sent.fn == FN_VICTIM && want.hit) victims_found++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sent = op_q.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.func  <= sent.fn;
          req_bus.key   <= sent.key;
          req_bus.now   <= sent.now;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    table_result_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_q.size() == 0) begin
          $error("response item with no request outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_bus.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
            errors++;
          end
          if (rsp_bus.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_bus.position);
            errors++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            errors++;
          end
          if (rsp_bus.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_bus.entry_count);
            errors++;
          end
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic push_op(func_e fn, logic [31:0] k, logic [31:0] t);
    table_op_t op;
    op.fn  = fn;
    op.key = k;
    op.now = t;
    op_q.push_back(op);
  endtask

  task automatic wait_drained();
    while (op_q.size() != 0 || req_bus.valid || expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] value);
    repeat (4) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid    <= 1'b0;
    shadow_threshold = value;
  endtask

  // walk flags step through the pool in order so the table fills or drains
  task automatic gen_mix(int n_items, int span, int pct_lookup, int pct_insert,
                         int pct_remove, bit walk_insert, bit walk_remove);
    int          roll;
    int          walk;
    func_e       fn;
    logic [31:0] k;
    walk = 0;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < pct_lookup) fn = FN_LOOKUP;
      else if (roll < pct_lookup + pct_insert) fn = FN_INSERT;
      else if (roll < pct_lookup + pct_insert + pct_remove) fn = FN_REMOVE;
      else fn = FN_VICTIM;
      roll = $urandom_range(99);
      if ((fn == FN_INSERT && walk_insert) || (fn == FN_REMOVE && walk_remove)) begin
        k = key_pool[walk % span];
        walk++;
      end else if (roll < 70) begin
        k = key_pool[$urandom_range(span - 1)];
      end else if (roll < 75) begin
        k = key_pool[$urandom_range(span - 1)] + 32'd1;
      end else if (roll < 80) begin
        k = key_pool[$urandom_range(span - 1)] - 32'd1;
      end else begin
        k = $urandom;
      end
      push_op(fn, k, tick);
      if ($urandom_range(99) < 3) tick = $urandom;
      else tick = tick + $urandom_range(8);
    end
  endtask

  initial begin : stimulus
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.func        = FN_LOOKUP;
    req_bus.key         = '0;
    req_bus.now         = '0;
    rsp_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.data        = '0;
    shadow_count        = 0;
    shadow_threshold    = IdleThresholdReset;
    send_idle_pct       = 0;
    rsp_stall_pct       = 0;
    errors              = 0;
    full_refusals       = 0;
    victims_found       = 0;
    peak_count          = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extreme keys, ties, wrapped idle time
    push_op(FN_LOOKUP, 32'h0000_0000, 32'd0);
    push_op(FN_VICTIM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(FN_REMOVE, 32'h0000_1234, 32'd1);
    push_op(FN_INSERT, 32'hFFFF_FFFF, 32'd5);
    push_op(FN_INSERT, 32'h0000_0000, 32'd5);
    push_op(FN_INSERT, 32'h8000_0000, 32'd5);
    push_op(FN_INSERT, 32'h0000_0000, 32'd7);
    push_op(FN_LOOKUP, 32'h8000_0000, 32'd10);
    push_op(FN_LOOKUP, 32'h7FFF_FFFF, 32'd11);
    push_op(FN_VICTIM, 32'h0000_0000, 32'd2000);
    push_op(FN_VICTIM, 32'h0000_0000, 32'd1005);
    push_op(FN_VICTIM, 32'h0000_0000, 32'd1006);
    push_op(FN_LOOKUP, 32'h0000_0000, 32'hFFFF_FFF0);
    push_op(FN_VICTIM, 32'h0000_0000, 32'd16);
    push_op(FN_VICTIM, 32'h0000_0000, 32'd3000);
    push_op(FN_REMOVE, 32'h8000_0000, 32'd3001);
    push_op(FN_REMOVE, 32'h8000_0000, 32'd3002);
    push_op(FN_REMOVE, 32'hFFFF_FFFF, 32'd3003);
    push_op(FN_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    push_op(FN_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555);
    push_op(FN_REMOVE, 32'h0000_0000, 32'd3004);
    push_op(FN_REMOVE, 32'h5555_5555, 32'd3005);
    push_op(FN_LOOKUP, 32'hFFFF_FFFF, 32'd3006);
    wait_drained();

    write_threshold(32'h0000_0000);
    send_idle_pct = 54;
    rsp_stall_pct = 0;
    tick = $urandom;
    gen_mix(300, 48, 35, 30, 25, 1'b0, 1'b0);
    wait_drained();

    // fill to capacity, then keep inserting into the full table
    write_threshold(32'hFFFF_FFFF);
    send_idle_pct = 0;
    rsp_stall_pct = 54;
    gen_mix(380, 300, 7, 85, 5, 1'b1, 1'b0);
    wait_drained();

    write_threshold($urandom_range(3000, 20));
    send_idle_pct = 37;
    rsp_stall_pct = 37;
    gen_mix(260, 300, 10, 5, 80, 1'b0, 1'b1);
    wait_drained();

    write_threshold(IdleThresholdReset);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    tick = 32'hFFFF_FE00;
    gen_mix(210, 64, 30, 30, 25, 1'b0, 1'b0);
    wait_drained();
    repeat (300) @(posedge clk_i);

    $display("ran %0d lookups, %0d inserts, %0d removes and %0d victim scans",
             op_tally[FN_LOOKUP], op_tally[FN_INSERT], op_tally[FN_REMOVE],
             op_tally[FN_VICTIM]);
    $display("table peaked at %0d entries, %0d inserts refused as full, %0d victims chosen",
             peak_count, full_refusals, victims_found);
    if (errors == 0) begin
      $display("sorted_key_cache_table_unit regression: pass");
    end else begin
      $display("sorted_key_cache_table_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("sorted_key_cache_table_unit regression: fail");
    $finish;
  end

endmodule
